// ===== sv/b64c_pkg.sv =====
// b64c_pkg: shared types, constants and alphabet functions of the base64 stream codec
// no dependencies; imported by the front, queue, back and top-level modules

package b64c_pkg;

    localparam logic       CMD_DATA  = 1'b0;
    localparam logic       CMD_EOS   = 1'b1;
    localparam logic       MODE_ENC  = 1'b0;
    localparam logic       MODE_DEC  = 1'b1;
    localparam logic [7:0] PAD_CHAR  = 8'h3D;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;
    localparam logic [1:0] PHASE_3 = 2'd3;

    // one queue entry: the results caused by one input item, emitted from byte 0 up
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
    } b64c_job_t;

    // 6-bit group to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] idx);
        logic [7:0] ch;
        if (idx < 6'd26)
            ch = 8'h41 + {2'b00, idx};
        else if (idx < 6'd52)
            ch = 8'h61 + {2'b00, idx - 6'd26};
        else if (idx < 6'd62)
            ch = 8'h30 + {2'b00, idx - 6'd52};
        else if (idx == 6'd62)
            ch = 8'h2B;
        else
            ch = 8'h2F;
        return ch;
    endfunction

    // alphabet character to 6-bit value, bit 6 set when the character is valid
    function automatic logic [6:0] dec_char(input logic [7:0] ch);
        logic [6:0] r;
        if (ch >= 8'h41 && ch <= 8'h5A)
            r = {1'b1, 6'(ch - 8'h41)};
        else if (ch >= 8'h61 && ch <= 8'h7A)
            r = {1'b1, 6'(ch - 8'h61 + 8'd26)};
        else if (ch >= 8'h30 && ch <= 8'h39)
            r = {1'b1, 6'(ch - 8'h30 + 8'd52)};
        else if (ch == 8'h2B)
            r = {1'b1, 6'd62};
        else if (ch == 8'h2F)
            r = {1'b1, 6'd63};
        else
            r = 7'd0;
        return r;
    endfunction

endpackage

// ===== sv/b64c_front.sv =====
// b64c_front: accepts items, holds mode, phase and carried bits, builds result jobs
// depends on b64c_pkg

module b64c_front
    import b64c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_cmd,
    input  logic [7:0] in_data,
    input  logic       q_ready,
    output logic       q_push,
    output b64c_job_t  q_job
);

    logic       mode_reg;
    logic [1:0] phase_reg,  phase_next;
    logic [7:0] carry_reg,  carry_next;
    logic       accept;
    logic [6:0] dec;
    logic [5:0] v;
    b64c_job_t  job;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign dec      = dec_char(in_data);
    assign v        = dec[5:0];

    always_comb
    begin
        phase_next = phase_reg;
        carry_next = carry_reg;
        job        = '0;
        if (in_cmd == CMD_EOS)
        begin
            if (mode_reg == MODE_ENC && (phase_reg == PHASE_1 || phase_reg == PHASE_2))
            begin
                job.bytes[0] = enc_char(carry_reg[5:0]);
                job.bytes[1] = PAD_CHAR;
                job.bytes[2] = PAD_CHAR;
                job.cnt      = (phase_reg == PHASE_1) ? 2'd3 : 2'd2;
            end
            phase_next = PHASE_0;
            carry_next = '0;
        end
        else if (mode_reg == MODE_ENC)
        begin
            case (phase_reg)
                PHASE_1:
                begin
                    job.bytes[0] = enc_char(carry_reg[5:0] | {2'b00, in_data[7:4]});
                    job.cnt      = 2'd1;
                    carry_next   = {2'b00, in_data[3:0], 2'b00};
                    phase_next   = PHASE_2;
                end
                PHASE_2:
                begin
                    job.bytes[0] = enc_char(carry_reg[5:0] | {4'b0000, in_data[7:6]});
                    job.bytes[1] = enc_char(in_data[5:0]);
                    job.cnt      = 2'd2;
                    carry_next   = '0;
                    phase_next   = PHASE_0;
                end
                default:
                begin
                    // phase 3 left over from decoding counts as phase 0
                    job.bytes[0] = enc_char(in_data[7:2]);
                    job.cnt      = 2'd1;
                    carry_next   = {2'b00, in_data[1:0], 4'b0000};
                    phase_next   = PHASE_1;
                end
            endcase
        end
        else if (dec[6])
        begin
            case (phase_reg)
                PHASE_0:
                begin
                    carry_next = {v, 2'b00};
                    phase_next = PHASE_1;
                end
                PHASE_1:
                begin
                    job.bytes[0] = carry_reg | {6'd0, v[5:4]};
                    job.cnt      = 2'd1;
                    carry_next   = {v[3:0], 4'b0000};
                    phase_next   = PHASE_2;
                end
                PHASE_2:
                begin
                    job.bytes[0] = carry_reg | {4'd0, v[5:2]};
                    job.cnt      = 2'd1;
                    carry_next   = {v[1:0], 6'd0};
                    phase_next   = PHASE_3;
                end
                default:
                begin
                    job.bytes[0] = carry_reg | {2'b00, v};
                    job.cnt      = 2'd1;
                    carry_next   = '0;
                    phase_next   = PHASE_0;
                end
            endcase
        end
    end

    assign q_push = accept && (job.cnt != 2'd0);
    assign q_job  = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ENC;
            phase_reg <= PHASE_0;
            carry_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (accept)
            begin
                phase_reg <= phase_next;
                carry_reg <= carry_next;
            end
        end
    end

endmodule

// ===== sv/b64c_queue.sv =====
// b64c_queue: short job queue between the front and the back
// depends on b64c_pkg

module b64c_queue
    import b64c_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  b64c_job_t push_job,
    output logic      not_full,
    input  logic      pop,
    output b64c_job_t pop_job,
    output logic      not_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    b64c_job_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign not_full  = (count_reg != CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (not_full || pop))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("job popped from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== sv/b64c_back.sv =====
// b64c_back: takes jobs from the queue and emits their bytes one a cycle while out_ready is high
// depends on b64c_pkg

module b64c_back
    import b64c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  b64c_job_t  q_job,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    b64c_job_t  cur_reg;
    logic       cur_valid_reg;
    logic [1:0] pos_reg;
    logic       is_last;

    assign is_last   = (pos_reg == cur_reg.cnt - 2'd1);
    assign out_valid = cur_valid_reg;
    assign out_last  = is_last;
    assign q_pop     = q_valid && (!cur_valid_reg || (out_ready && is_last));

    always_comb
    begin
        case (pos_reg)
            2'd0:    out_byte = cur_reg.bytes[0];
            2'd1:    out_byte = cur_reg.bytes[1];
            default: out_byte = cur_reg.bytes[2];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else if (q_pop)
        begin
            cur_valid_reg <= 1'b1;
            pos_reg       <= '0;
        end
        else if (cur_valid_reg && out_ready)
        begin
            if (is_last)
                cur_valid_reg <= 1'b0;
            else
                pos_reg <= pos_reg + 2'd1;
        end
    end

    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.cnt != 2'd0))
        else $error("empty job loaded into the back end");

    a_pos_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (pos_reg < cur_reg.cnt))
        else $error("byte position past end of job");

    a_advance_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && out_ready && !is_last) |=> (pos_reg == $past(pos_reg) + 2'd1))
        else $error("byte position did not advance after a take");

endmodule

// ===== sv/base64_stream_codec.sv =====
// base64_stream_codec: top level of the streaming base64 encoder / decoder
// depends on b64c_pkg, b64c_front, b64c_queue, b64c_back
//
// Items arrive on s_axis (tuser = end-of-stream flag, tdata = byte) and are
// taken one per cycle whenever the job queue has room; each item's results
// (zero to three bytes, tlast on the final one) leave on m_axis one byte per
// cycle while m_axis_tready is high, via the job queue and the back end's
// current-job register. Encoding rate is set by the single output port, four
// characters per three raw bytes; decoding takes up to one character per
// cycle. cfg_wr_en/cfg_wr_data write the mode (0 encode, 1 decode) and
// should only be used while no items are in flight.

module base64_stream_codec
    import b64c_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,      // mode
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,     // [7:0] data
    input  logic       s_axis_tuser,     // [0] cmd
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,     // [7:0] out_byte
    output logic       m_axis_tlast
);

    logic      q_push, q_pop, q_not_full, q_not_empty;
    b64c_job_t push_job, pop_job;

    b64c_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (s_axis_tuser),
        .in_data     (s_axis_tdata),
        .q_ready     (q_not_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .pop_job   (pop_job),
        .not_empty (q_not_empty)
    );

    b64c_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_job     (pop_job),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
